// ----- rtl/name_and_path_validator_top_assert.svh -----
// Assertion macros shared by the validator checkers (expect clk and rst in scope).
`ifndef NAME_AND_PATH_VALIDATOR_TOP_ASSERT_SVH
`define NAME_AND_PATH_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, skipped while in reset.
`define NPV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npv assertion failed");

// Next-cycle implication, skipped while in reset.
`define NPV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npv assertion failed");

`endif

// ----- rtl/npv_pkg.sv -----
// Shared constants, types and character helpers for the name/path validator.
`default_nettype none
package npv_pkg;

  // Length limits and counter widths
  localparam int NAME_MAX = 63;
  localparam int PATH_MAX = 255;
  localparam int CNT_W    = 9;
  localparam int SEG_W    = 2;
  localparam int STATUS_W = 3;

  // Characters with special meaning
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_LEAD_DASH  = 3'd3,
    ST_FORBIDDEN  = 3'd4,
    ST_SLASH_EDGE = 3'd5,
    ST_DOTDOT     = 3'd6,
    ST_NOT_LETTER = 3'd7
  } status_t;

  // Classification of one incoming byte
  typedef struct packed {
    logic allowed;
    logic is_dot;
    logic is_slash;
  } char_class_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/npv_char_class.sv -----
// Byte classifier: allowed set per mode plus dot and slash detection.
`default_nettype none
module npv_char_class (
  input  logic [7:0]          char_byte,
  input  logic                path_mode,
  output npv_pkg::char_class_t cls
);
  import npv_pkg::*;

  logic base_ok;
  logic path_extra;

  // Letters, digits, dash and underscore pass in both modes
  assign base_ok = is_letter(char_byte) || is_digit(char_byte) ||
                   (char_byte == CH_DASH) || (char_byte == CH_UNDER);

  // Path mode also takes dot, slash and colon
  assign path_extra = (char_byte == CH_DOT) || (char_byte == CH_SLASH) ||
                      (char_byte == CH_COLON);

  always_comb begin
    cls.allowed  = base_ok || (path_mode && path_extra);
    cls.is_dot   = (char_byte == CH_DOT);
    cls.is_slash = (char_byte == CH_SLASH);
  end

endmodule
`default_nettype wire

// ----- rtl/name_and_path_validator_top.sv -----
// Top level of the name/dataset path validator: request stage, running flags, result register.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  request   | item_valid / item_ready   | char_byte, last, empty_string
//  result    | result_valid/result_ready | status
//  config    | cfg_we (no wait)          | cfg_wdata (mode)
//
// One request per clock sustained, but for the stall below; status is registered in the
// result register when the string-ending request moves on from the request register.
// Synchronous active-high rst clears the mode, the running flags and both valid bits.
// item_ready drops only while a string-ending request waits behind a result that
// has not been taken; requests that end nothing always move on.
`default_nettype none
module name_and_path_validator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [7:0]                    char_byte,
  input  logic                          last,
  input  logic                          empty_string,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [npv_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata
);
  import npv_pkg::*;

  localparam logic [CNT_W-1:0] NAME_LIM = CNT_W'(NAME_MAX);
  localparam logic [CNT_W-1:0] PATH_LIM = CNT_W'(PATH_MAX);
  localparam logic [SEG_W-1:0] SEG_SAT  = {SEG_W{1'b1}};
  localparam logic [SEG_W-1:0] SEG_TWO  = SEG_W'(2);

  // Mode register
  logic mode;

  // Request stage
  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_last;
  logic       stage_empty;

  // Running flags for the current string
  logic [CNT_W-1:0] char_count;
  logic [7:0]       first_char;
  logic [SEG_W-1:0] seg_len;
  logic             seg_dots;
  logic             forbidden_seen;
  logic             dotdot_seen;

  logic [CNT_W-1:0] char_count_next;
  logic [7:0]       first_char_next;
  logic [SEG_W-1:0] seg_len_next;
  logic             seg_dots_next;
  logic             forbidden_seen_next;
  logic             dotdot_seen_next;
  logic             dotdot_final;

  logic [CNT_W-1:0] limit;
  char_class_t      cls;
  status_t          status_calc;
  logic             stage_ends;
  logic             stage_go;
  logic             load;

  npv_char_class u_cls (
    .char_byte (stage_char),
    .path_mode (mode),
    .cls       (cls)
  );

  // Flow control: a string end needs room in the result register
  assign stage_ends = stage_last | stage_empty;
  assign stage_go   = stage_valid & (~stage_ends | ~result_valid | result_ready);
  assign item_ready = ~stage_valid | stage_go;
  assign load       = item_valid & item_ready;

  // Flag updates for the byte in the stage
  always_comb begin
    limit               = mode ? PATH_LIM : NAME_LIM;
    char_count_next     = (char_count < limit + CNT_W'(1)) ? char_count + CNT_W'(1)
                                                           : char_count;
    first_char_next     = (char_count == '0) ? stage_char : first_char;
    forbidden_seen_next = forbidden_seen | ~cls.allowed;
    if (cls.is_slash) begin
      dotdot_seen_next = dotdot_seen | ((seg_len == SEG_TWO) & seg_dots);
      seg_len_next     = '0;
      seg_dots_next    = 1'b1;
    end else begin
      dotdot_seen_next = dotdot_seen;
      seg_len_next     = (seg_len == SEG_SAT) ? seg_len : seg_len + SEG_W'(1);
      seg_dots_next    = seg_dots & cls.is_dot;
    end
    // Last byte closes the open segment unless it was a slash
    dotdot_final = dotdot_seen_next |
                   (~cls.is_slash & (seg_len_next == SEG_TWO) & seg_dots_next);
  end

  // Status in order of precedence
  always_comb begin
    status_calc = ST_OK;
    if (stage_empty) begin
      status_calc = mode ? ST_OK : ST_EMPTY;
    end else if (!mode) begin
      if (char_count_next > NAME_LIM) begin
        status_calc = ST_TOO_LONG;
      end else if (first_char_next == CH_DASH || first_char_next == CH_DOT) begin
        status_calc = ST_LEAD_DASH;
      end else if (forbidden_seen_next) begin
        status_calc = ST_FORBIDDEN;
      end
    end else begin
      if (char_count_next > PATH_LIM) begin
        status_calc = ST_TOO_LONG;
      end else if (first_char_next == CH_SLASH || cls.is_slash) begin
        status_calc = ST_SLASH_EDGE;
      end else if (dotdot_final) begin
        status_calc = ST_DOTDOT;
      end else if (!is_letter(first_char_next)) begin
        status_calc = ST_NOT_LETTER;
      end else if (forbidden_seen_next) begin
        status_calc = ST_FORBIDDEN;
      end
    end
  end

  // Request payload register
  always_ff @(posedge clk) begin
    if (load) begin
      stage_char  <= char_byte;
      stage_last  <= last;
      stage_empty <= empty_string;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (stage_go && stage_ends) begin
      status <= status_calc;
    end
  end

  // Control, mode and running flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 1'b0;
      stage_valid    <= 1'b0;
      result_valid   <= 1'b0;
      char_count     <= '0;
      first_char     <= '0;
      seg_len        <= '0;
      seg_dots       <= 1'b1;
      forbidden_seen <= 1'b0;
      dotdot_seen    <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (item_ready) begin
        stage_valid <= item_valid;
      end
      // A new status fills the slot; otherwise it empties once taken
      result_valid <= (stage_go & stage_ends) | (result_valid & ~result_ready);
      if (stage_go) begin
        if (stage_ends) begin
          char_count     <= '0;
          first_char     <= '0;
          seg_len        <= '0;
          seg_dots       <= 1'b1;
          forbidden_seen <= 1'b0;
          dotdot_seen    <= 1'b0;
        end else begin
          char_count     <= char_count_next;
          first_char     <= first_char_next;
          seg_len        <= seg_len_next;
          seg_dots       <= seg_dots_next;
          forbidden_seen <= forbidden_seen_next;
          dotdot_seen    <= dotdot_seen_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/npv_checker.sv -----
// Port-level checker for the validator top, attached by bind.
`default_nettype none
`include "name_and_path_validator_top_assert.svh"
module npv_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_valid,
  input wire logic                          item_ready,
  input wire logic                          last,
  input wire logic                          empty_string,
  input wire logic                          result_valid,
  input wire logic                          result_ready,
  input wire logic [npv_pkg::STATUS_W-1:0]  status
);

  // A result waiting to be taken stays put
  `NPV_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(status))

  // Requests stall only behind a result that is not being taken
  `NPV_ASSERT_IMP(a_stall_cause, !item_ready, result_valid && !result_ready)

  // A fresh result comes from an accepted string-ending request, via the request register
  `NPV_ASSERT_IMP(a_result_source, $rose(result_valid),
                  $past(item_valid && item_ready && (last || empty_string), 2))

endmodule

bind name_and_path_validator_top npv_checker u_npv_checker (.*);
`default_nettype wire
